// File: rtl/ais_pkg.sv
// ----------------------------------------------------------------------------
// ais_pkg
// shared types, constants and character helpers for the sentence checker
// ----------------------------------------------------------------------------
package ais_pkg;

  localparam int unsigned MaxLineDef = 128;
  localparam int unsigned HdrBytes   = 15;

  // verdict codes
  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_IGNORED  = 4'd1,
    ST_SHORT    = 4'd2,
    ST_TALKER   = 4'd3,
    ST_HEADER   = 4'd4,
    ST_TAIL     = 4'd5,
    ST_FILL     = 4'd6,
    ST_ID       = 4'd7,
    ST_CHANNEL  = 4'd8,
    ST_EMPTY    = 4'd9,
    ST_CHAR     = 4'd10,
    ST_PARTS    = 4'd11,
    ST_CHECKSUM = 4'd12
  } status_t;

  // register indexes
  localparam logic CFG_DROP_BAD = 1'b0;
  localparam logic CFG_OWN_VES  = 1'b1;

  // closed line handed from front to back
  typedef struct packed {
    logic [14:0][7:0] hdr;
    logic [39:0]      tail;
    logic [7:0]       xsum;
    status_t          ferr;
    logic [10:0]      len;
  } line_t;

  // decoded verdict
  typedef struct packed {
    status_t    status;
    logic       checksum_bad;
    logic [7:0] talker_first;
    logic [7:0] talker_second;
    logic [3:0] fragment_count;
    logic [3:0] fragment_number;
    logic [7:0] sequence_char;
    logic [7:0] radio_channel;
    logic [2:0] fill_bits;
    logic [7:0] payload_chars;
  } verdict_t;

  function automatic logic payload_ok(input logic [7:0] c);
    payload_ok = (c >= 8'h30 && c < 8'h58) || (c >= 8'h60 && c < 8'h78);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= "0" && c <= "9") v = c - 8'h30;
    else if (c >= "A" && c <= "F") v = c - 8'h37;
    else if (c >= "a" && c <= "f") v = c - 8'h57;
    hex_val = v[3:0];
  endfunction

endpackage

// File: rtl/ais_front.sv
// ----------------------------------------------------------------------------
// ais_front
// byte framing: collects a line, tracks checksum, tail and payload errors
// ----------------------------------------------------------------------------
module ais_front #(
  parameter int unsigned MAX_LINE = ais_pkg::MaxLineDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_vld,
  input  logic [7:0]        byte_in,
  output logic              line_vld,
  output ais_pkg::line_t    line_out
);
  import ais_pkg::*;

  localparam int unsigned LW = 11;

  typedef enum logic [1:0] {PH_WAIT, PH_LINE, PH_SKIP} phase_t;

  phase_t           phase_r, phase_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [7:0]       xsum_r, xsum_nxt;
  status_t          ferr_r, ferr_nxt;
  logic [39:0]      tail_r, tail_nxt;
  logic [14:0][7:0] hdr_r, hdr_nxt;
  logic             line_vld_nxt;

  // per byte line tracking
  always_comb begin
    phase_nxt    = phase_r;
    len_nxt      = len_r;
    xsum_nxt     = xsum_r;
    ferr_nxt     = ferr_r;
    tail_nxt     = tail_r;
    hdr_nxt      = hdr_r;
    line_vld_nxt = 1'b0;
    if (byte_vld) begin
      case (phase_r)
        PH_SKIP: begin
          if (byte_in == 8'h0A) phase_nxt = PH_WAIT;
        end
        PH_LINE: begin
          if (byte_in <= 8'h20) begin
            line_vld_nxt = 1'b1;
            phase_nxt    = PH_WAIT;
          end else if (len_r >= LW'(MAX_LINE)) begin
            phase_nxt = PH_SKIP;
          end else begin
            if (len_r < LW'(HdrBytes)) hdr_nxt[len_r[3:0]] = byte_in;
            if (len_r >= LW'(HdrBytes + 5) && ferr_r == ST_OK &&
                !payload_ok(tail_r[39:32]))
              ferr_nxt = (tail_r[39:32] == ",") ? ST_PARTS : ST_CHAR;
            xsum_nxt = xsum_r ^ byte_in;
            tail_nxt = {tail_r[31:0], byte_in};
            len_nxt  = len_r + LW'(1);
          end
        end
        default: begin
          if (byte_in > 8'h20) begin
            hdr_nxt  = '0;
            xsum_nxt = 8'd0;
            ferr_nxt = ST_OK;
            if (byte_in == "$" || byte_in == "!") begin
              phase_nxt = PH_LINE;
              hdr_nxt[0] = byte_in;
              tail_nxt   = {32'd0, byte_in};
              len_nxt    = LW'(1);
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      len_r    <= '0;
      ferr_r   <= ST_OK;
      line_vld <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      ferr_r   <= ferr_nxt;
      line_vld <= line_vld_nxt;
    end
    xsum_r <= xsum_nxt;
    tail_r <= tail_nxt;
    hdr_r  <= hdr_nxt;
  end

  assign line_out = '{hdr: hdr_r, tail: tail_r, xsum: xsum_r, ferr: ferr_r, len: len_r};

endmodule

// File: rtl/ais_back.sv
// ----------------------------------------------------------------------------
// ais_back
// verdict logic: header and tail checks on a closed line, one line a cycle
// ----------------------------------------------------------------------------
module ais_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            drop_bad,
  input  logic            own_ves,
  input  logic            line_vld,
  input  ais_pkg::line_t  line_in,
  output logic            vrd_vld,
  output ais_pkg::verdict_t vrd_out
);
  import ais_pkg::*;

  verdict_t v;
  logic [7:0] b [15];
  logic [7:0] t0, t1, t2, t3, t4, cs, rx;
  logic [4:0] q;
  logic [10:0] pend, cnt;
  logic [7:0] idc, ch;
  logic pay_done;
  status_t st;

  always_comb begin
    for (int k = 0; k < 15; k++) b[k] = line_in.hdr[k];
    t0 = line_in.tail[7:0];
    t1 = line_in.tail[15:8];
    t2 = line_in.tail[23:16];
    t3 = line_in.tail[31:24];
    t4 = line_in.tail[39:32];
    v = '0;
    v.status = ST_OK;
    idc = 8'd0;
    ch  = "?";
    q   = 5'd11;
    pend = line_in.len - 11'd5;
    st = ST_OK;
    pay_done = 1'b0;
    cnt = 11'd0;
    if (b[11] != ",") begin idc = b[11]; q = 5'd12; end
    if (b[q[3:0]] == ",") begin
      q = q + 5'd1;
      if (b[q[3:0]] != ",") begin ch = b[q[3:0]]; q = q + 5'd1; end
    end
    // header-area payload scan, up to four bytes
    for (int i = 11; i < 15; i++) begin
      if (!pay_done && 5'(i) > q && 11'(i) < pend && !payload_ok(b[i])) begin
        st = (b[i] == ",") ? ST_PARTS : ST_CHAR;
        pay_done = 1'b1;
      end
    end
    if (st == ST_OK) st = line_in.ferr;
    cs = line_in.xsum ^ t0 ^ t1 ^ t2;
    rx = {hex_val(t1), hex_val(t0)};
    if (line_in.len <= 11'd5 ||
        !(b[3] == "V" && b[4] == "D" && (b[5] == "M" || (b[5] == "O" && own_ves))))
      v.status = ST_IGNORED;
    else if (line_in.len < 11'd18) v.status = ST_SHORT;
    else if (!(b[1] >= "A" && b[1] <= "Z") ||
             (!(b[2] >= "A" && b[2] <= "Z") && !(b[2] >= "0" && b[2] <= "9")))
      v.status = ST_TALKER;
    else if (b[6] != "," || b[8] != "," || b[10] != "," || b[7] < "1" || b[7] > "9" ||
             b[9] < "1" || b[9] > "9")
      v.status = ST_HEADER;
    else if (!is_hex(t0) || !is_hex(t1) || t2 != "*" || t4 != ",") v.status = ST_TAIL;
    else if (t3 < "0" || t3 > "5") v.status = ST_FILL;
    else if (b[q[3:0]] != "," && q <= 5'd12) v.status = ST_ID;
    else if (b[11] != "," && b[12] != ",") v.status = ST_ID;
    else if (b[q[3:0]] != ",") v.status = ST_CHANNEL;
    else if (11'(q) + 11'd1 > pend) v.status = ST_EMPTY;
    else if (st != ST_OK) v.status = st;
    else begin
      cnt = pend - 11'(q) - 11'd1;
      v.checksum_bad    = (cs != rx);
      v.status          = (cs != rx && drop_bad) ? ST_CHECKSUM : ST_OK;
      v.talker_first    = b[1];
      v.talker_second   = b[2];
      v.fragment_count  = 4'(b[7] - 8'h30);
      v.fragment_number = 4'(b[9] - 8'h30);
      v.sequence_char   = idc;
      v.radio_channel   = ch;
      v.fill_bits       = 3'(t3 - 8'h30);
      v.payload_chars   = (cnt > 11'd255) ? 8'd255 : cnt[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vrd_vld <= 1'b0;
    else vrd_vld <= line_vld;
    vrd_out <= v;
  end

endmodule

// File: rtl/ais_fifo.sv
// ----------------------------------------------------------------------------
// ais_fifo
// small result queue presenting the oldest verdict to the consumer
// ----------------------------------------------------------------------------
module ais_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  ais_pkg::verdict_t wdata,
  input  logic              rd,
  output ais_pkg::verdict_t rdata,
  output logic              empty,
  output logic              almost_full
);
  import ais_pkg::*;

  verdict_t    mem [4];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
    if (wr) mem[wp_r] <= wdata;
  end

  assign rdata       = mem[rp_r];
  assign empty       = (cnt_r == 3'd0);
  // at most one more verdict is still in flight when this rises
  assign almost_full = (cnt_r >= 3'd2);

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 3'd4 |-> !wr) else $error("result queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    rd |-> !empty) else $error("result queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("result count out of range");
`endif

endmodule

// File: rtl/ais_sentence_checker_top.sv
// ----------------------------------------------------------------------------
// ais_sentence_checker_top
// AIVDM/AIVDO sentence checker with queue-style byte input and verdict output
// ----------------------------------------------------------------------------
// Takes one byte per cycle while full is low; the front tracks the line and
// registers it when the terminator arrives, the back registers the verdict
// formed from that line, and the verdict is then written to the result queue. A four
// entry result queue decouples the consumer; full rises when two verdicts wait.
module ais_sentence_checker_top #(
  parameter int unsigned MAX_LINE = ais_pkg::MaxLineDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] out_status,
  output logic       out_checksum_bad,
  output logic [7:0] out_talker_first,
  output logic [7:0] out_talker_second,
  output logic [3:0] out_fragment_count,
  output logic [3:0] out_fragment_number,
  output logic [7:0] out_sequence_char,
  output logic [7:0] out_radio_channel,
  output logic [2:0] out_fill_bits,
  output logic [7:0] out_payload_chars
);
  import ais_pkg::*;

  logic     drop_r, own_r;
  logic     acc, line_vld, vrd_vld;
  line_t    line_w;
  verdict_t vrd_w, head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_r <= 1'b1;
      own_r  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DROP_BAD) drop_r <= cfg_wdata;
      if (cfg_index == CFG_OWN_VES)  own_r  <= cfg_wdata;
    end
  end

  assign acc = push && !full;

  ais_front #(.MAX_LINE(MAX_LINE)) u_front (
    .clk(clk), .rst_n(rst_n), .byte_vld(acc), .byte_in(in_rx_byte),
    .line_vld(line_vld), .line_out(line_w)
  );

  ais_back u_back (
    .clk(clk), .rst_n(rst_n), .drop_bad(drop_r), .own_ves(own_r),
    .line_vld(line_vld), .line_in(line_w), .vrd_vld(vrd_vld), .vrd_out(vrd_w)
  );

  ais_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr(vrd_vld), .wdata(vrd_w), .rd(pop && !empty),
    .rdata(head), .empty(empty), .almost_full(full)
  );

  assign out_status          = head.status;
  assign out_checksum_bad    = head.checksum_bad;
  assign out_talker_first    = head.talker_first;
  assign out_talker_second   = head.talker_second;
  assign out_fragment_count  = head.fragment_count;
  assign out_fragment_number = head.fragment_number;
  assign out_sequence_char   = head.sequence_char;
  assign out_radio_channel   = head.radio_channel;
  assign out_fill_bits       = head.fill_bits;
  assign out_payload_chars   = head.payload_chars;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// byte-stream test of the AIVDM/AIVDO sentence checker: directed sentences
// for every verdict, then random well-formed, damaged and noisy lines; each
// verdict is predicted per accepted byte and compared field by field
// ----------------------------------------------------------------------------
module testbench;
  import ais_pkg::*;

  localparam int MaxLine   = 128;
  localparam int Settle    = 8;
  localparam int HoldLen   = 300;
  localparam int NoCheck   = -1;

  typedef enum {LN_WAIT, LN_LINE, LN_SKIP} line_phase_t;

  typedef struct {
    logic [7:0] b;
    int         st;
  } tx_byte_t;

  typedef struct {
    string body;
    bit    add_cs;
    int    st;
  } row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic       cfg_wdata;
  logic       push;
  logic       full;
  logic [7:0] in_rx_byte;
  logic       empty;
  logic       pop;
  logic [3:0] out_status;
  logic       out_checksum_bad;
  logic [7:0] out_talker_first;
  logic [7:0] out_talker_second;
  logic [3:0] out_fragment_count;
  logic [3:0] out_fragment_number;
  logic [7:0] out_sequence_char;
  logic [7:0] out_radio_channel;
  logic [2:0] out_fill_bits;
  logic [7:0] out_payload_chars;

  ais_sentence_checker_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .push               (push),
    .full               (full),
    .in_rx_byte         (in_rx_byte),
    .empty              (empty),
    .pop                (pop),
    .out_status         (out_status),
    .out_checksum_bad   (out_checksum_bad),
    .out_talker_first   (out_talker_first),
    .out_talker_second  (out_talker_second),
    .out_fragment_count (out_fragment_count),
    .out_fragment_number(out_fragment_number),
    .out_sequence_char  (out_sequence_char),
    .out_radio_channel  (out_radio_channel),
    .out_fill_bits      (out_fill_bits),
    .out_payload_chars  (out_payload_chars)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  initial begin
    #(12 * 1500000);
    $display("Simulation FAILED");
    $finish;
  end

  // checker state mirror
  logic        drop_bad;
  logic        own_ves;
  line_phase_t lphase;
  int          line_len;
  logic [7:0]  xsum;
  status_t     ferr;
  logic [39:0] tail;
  logic [7:0]  hdr [0:14];

  tx_byte_t   tx_q [$];
  verdict_t   verdict_q [$];
  int         mismatches;
  int         verdicts_seen;
  int         bytes_queued;
  bit         quiet;
  bit         hold_go;
  bit         hold_done;
  logic [7:0] line_buf [$];

  function automatic bit pl_char(input logic [7:0] c);
    return (c >= 8'h30 && c < 8'h58) || (c >= 8'h60 && c < 8'h78);
  endfunction

  function automatic bit hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    return 4'd0;
  endfunction

  function automatic logic [7:0] tb8(input int k);
    return tail[8*k +: 8];
  endfunction

  function automatic void clear_line();
    line_len = 0;
    xsum = 8'd0;
    ferr = ST_OK;
    tail = 40'd0;
    for (int i = 0; i < 15; i++) hdr[i] = 8'd0;
  endfunction

  // verdict for the closed line
  function automatic verdict_t judge_line();
    verdict_t v;
    int q, pend;
    logic [7:0] idc, chv, cs, rx;
    status_t st;
    v = '0;
    idc = 8'd0;
    chv = "?";
    if (line_len <= 5 || !(hdr[3] == "V" && hdr[4] == "D" &&
        (hdr[5] == "M" || (hdr[5] == "O" && own_ves)))) begin
      v.status = ST_IGNORED;
      return v;
    end
    if (line_len < 18) begin
      v.status = ST_SHORT;
      return v;
    end
    if (!(hdr[1] >= "A" && hdr[1] <= "Z") ||
        (!(hdr[2] >= "A" && hdr[2] <= "Z") && !(hdr[2] >= "0" && hdr[2] <= "9"))) begin
      v.status = ST_TALKER;
      return v;
    end
    if (hdr[6] != "," || hdr[8] != "," || hdr[10] != "," ||
        hdr[7] < "1" || hdr[7] > "9" || hdr[9] < "1" || hdr[9] > "9") begin
      v.status = ST_HEADER;
      return v;
    end
    if (!hex_char(tb8(0)) || !hex_char(tb8(1)) || tb8(2) != "*" || tb8(4) != ",") begin
      v.status = ST_TAIL;
      return v;
    end
    if (tb8(3) < "0" || tb8(3) > "5") begin
      v.status = ST_FILL;
      return v;
    end
    q = 11;
    if (hdr[q] != ",") begin
      idc = hdr[q];
      q++;
    end
    if (hdr[q] != ",") begin
      v.status = ST_ID;
      return v;
    end
    q++;
    if (hdr[q] != ",") begin
      chv = hdr[q];
      q++;
    end
    if (hdr[q] != ",") begin
      v.status = ST_CHANNEL;
      return v;
    end
    q++;
    pend = line_len - 5;
    if (q > pend) begin
      v.status = ST_EMPTY;
      return v;
    end
    st = ST_OK;
    for (int i = q; i < 15 && i < pend; i++) begin
      if (st == ST_OK && !pl_char(hdr[i])) st = (hdr[i] == ",") ? ST_PARTS : ST_CHAR;
    end
    if (st == ST_OK) st = ferr;
    if (st != ST_OK) begin
      v.status = st;
      return v;
    end
    cs = xsum ^ tb8(0) ^ tb8(1) ^ tb8(2);
    rx = {nibble_of(tb8(1)), nibble_of(tb8(0))};
    v.status = ST_OK;
    if (cs != rx) begin
      v.checksum_bad = 1'b1;
      if (drop_bad) v.status = ST_CHECKSUM;
    end
    v.talker_first    = hdr[1];
    v.talker_second   = hdr[2];
    v.fragment_count  = 4'(hdr[7] - "0");
    v.fragment_number = 4'(hdr[9] - "0");
    v.sequence_char   = idc;
    v.radio_channel   = chv;
    v.fill_bits       = 3'(tb8(3) - "0");
    v.payload_chars   = (pend - q > 255) ? 8'd255 : 8'(pend - q);
    return v;
  endfunction

  // one accepted byte; returns 1 when it closes a line
  function automatic bit take_byte(input logic [7:0] c, output verdict_t v);
    logic [7:0] old;
    v = '0;
    if (lphase == LN_SKIP) begin
      if (c == 8'h0A) lphase = LN_WAIT;
      return 1'b0;
    end
    if (lphase != LN_LINE) begin
      if (c <= 8'h20) return 1'b0;
      clear_line();
      if (c == "$" || c == "!") begin
        lphase = LN_LINE;
        hdr[0] = c;
        tail = {32'd0, c};
        line_len = 1;
      end else begin
        lphase = LN_SKIP;
      end
      return 1'b0;
    end
    if (c <= 8'h20) begin
      v = judge_line();
      lphase = LN_WAIT;
      clear_line();
      return 1'b1;
    end
    if (line_len >= MaxLine) begin
      lphase = LN_SKIP;
      clear_line();
      return 1'b0;
    end
    if (line_len < 15) hdr[line_len] = c;
    if (line_len >= 20 && ferr == ST_OK) begin
      old = tb8(4);
      if (!pl_char(old)) ferr = (old == ",") ? ST_PARTS : ST_CHAR;
    end
    xsum = xsum ^ c;
    tail = {tail[31:0], c};
    line_len++;
    return 1'b1 == 1'b0;
  endfunction

  // sender: one byte request per cycle, held while full, random gaps
  int tx_gap;
  always @(posedge clk) begin
    verdict_t v;
    tx_byte_t t;
    if (!rst_n) begin
      push <= 1'b0;
      in_rx_byte <= 8'd0;
      tx_gap = 0;
      lphase = LN_WAIT;
      clear_line();
    end else begin
      if (push && !full) begin
        t = tx_q.pop_front();
        if (take_byte(t.b, v)) begin
          verdict_q = {verdict_q, v};
          if (t.st != NoCheck && int'(v.status) != t.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("table row status: predicted %0d, listed %0d", v.status, t.st);
          end
        end
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (!quiet && tx_q.size() > 0 && $urandom_range(0, 24) == 0) begin
        tx_gap = $urandom_range(0, 16);
        push <= 1'b0;
      end else if (tx_q.size() > 0) begin
        push <= 1'b1;
        in_rx_byte <= tx_q[0].b;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: random stalls and one long hold-off
  int rx_stall;
  int rx_hold;
  always @(posedge clk) begin
    verdict_t e;
    bit bad;
    if (!rst_n) begin
      pop <= 1'b0;
      rx_stall = 0;
      rx_hold = 0;
    end else begin
      if (pop && !empty) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("verdict with no request pending: status %0d", out_status);
        end else begin
          e = verdict_q.pop_front();
          bad = (out_status != e.status) || (out_checksum_bad != e.checksum_bad) ||
                (out_talker_first != e.talker_first) ||
                (out_talker_second != e.talker_second) ||
                (out_fragment_count != e.fragment_count) ||
                (out_fragment_number != e.fragment_number) ||
                (out_sequence_char != e.sequence_char) ||
                (out_radio_channel != e.radio_channel) ||
                (out_fill_bits != e.fill_bits) || (out_payload_chars != e.payload_chars);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("verdict mismatch exp %0d %0d %h %h %0d %0d %h %h %0d %0d got %0d %0d %h %h %0d %0d %h %h %0d %0d",
                       e.status, e.checksum_bad, e.talker_first, e.talker_second,
                       e.fragment_count, e.fragment_number, e.sequence_char,
                       e.radio_channel, e.fill_bits, e.payload_chars,
                       out_status, out_checksum_bad, out_talker_first, out_talker_second,
                       out_fragment_count, out_fragment_number, out_sequence_char,
                       out_radio_channel, out_fill_bits, out_payload_chars);
          end
        end
      end
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        rx_hold = HoldLen;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        rx_stall = $urandom_range(0, 16);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
    if (n < 10) return 8'("0" + n);
    return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
  endfunction

  task automatic queue_byte(input logic [7:0] b, input int st);
    tx_byte_t t;
    t.b = b;
    t.st = st;
    tx_q = {tx_q, t};
    bytes_queued++;
  endtask

  // text line of the table, optional checksum, CR LF ending
  task automatic queue_text(input string s, input bit add_cs, input int st);
    logic [7:0] x;
    x = 8'd0;
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i], NoCheck);
      if (i > 0) x ^= s[i];
    end
    if (add_cs) begin
      queue_byte("*", NoCheck);
      queue_byte(hex_digit(x[7:4], 1'b0), NoCheck);
      queue_byte(hex_digit(x[3:0], 1'b0), NoCheck);
    end
    queue_byte(8'h0D, st);
    queue_byte(8'h0A, NoCheck);
  endtask

  function automatic logic [7:0] armor_char();
    int v;
    v = $urandom_range(0, 63);
    return (v < 40) ? 8'(8'h30 + v) : 8'(8'h60 + v - 40);
  endfunction

  // one more byte of the sentence being built
  task automatic append_char(input logic [7:0] c);
    line_buf = {line_buf, c};
  endtask

  // random sentence, mostly well formed, sometimes damaged
  task automatic queue_sentence();
    logic [7:0] x;
    int n, k;
    bit lower;
    line_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)), NoCheck);
      queue_byte(8'h0A, NoCheck);
    end
    append_char($urandom_range(0, 7) == 0 ? "$" : "!");
    if ($urandom_range(0, 5) == 0) begin
      append_char(8'($urandom_range(8'h21, 8'hFF)));
      append_char(8'($urandom_range(8'h21, 8'hFF)));
    end else begin
      append_char(8'("A" + $urandom_range(0, 25)));
      append_char($urandom_range(0, 1) ? 8'("A" + $urandom_range(0, 25))
                                       : 8'("0" + $urandom_range(0, 9)));
    end
    append_char("V");
    append_char("D");
    append_char($urandom_range(0, 3) == 0 ? "O" : "M");
    append_char(",");
    append_char(8'("1" + $urandom_range(0, 8)));
    append_char(",");
    append_char(8'("1" + $urandom_range(0, 8)));
    append_char(",");
    if ($urandom_range(0, 1)) append_char(8'("0" + $urandom_range(0, 9)));
    append_char(",");
    if ($urandom_range(0, 9) > 2) append_char($urandom_range(0, 1) ? "A" : "B");
    append_char(",");
    n = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 130) : $urandom_range(0, 23);
    for (int i = 0; i < n; i++) append_char(armor_char());
    append_char(",");
    append_char(8'("0" + $urandom_range(0, 5)));
    x = 8'd0;
    for (int i = 1; i < line_buf.size(); i++) x ^= line_buf[i];
    if ($urandom_range(0, 7) == 0) x ^= 8'($urandom_range(1, 255));
    lower = $urandom_range(0, 1);
    append_char("*");
    append_char(hex_digit(x[7:4], lower));
    append_char(hex_digit(x[3:0], lower));
    // damage: one byte replaced, or the line cut short
    k = $urandom_range(0, 11);
    if (k < 2) begin
      line_buf[$urandom_range(1, line_buf.size() - 1)] =
        (k == 0) ? "," : 8'($urandom_range(8'h21, 8'hFF));
    end else if (k == 2) begin
      n = $urandom_range(1, line_buf.size() - 1);
      while (line_buf.size() > n) void'(line_buf.pop_back());
    end
    foreach (line_buf[i]) queue_byte(line_buf[i], NoCheck);
    if ($urandom_range(0, 4) == 0) begin
      queue_byte(8'($urandom_range(0, 8'h20)), NoCheck);
    end else begin
      queue_byte(8'h0D, NoCheck);
      queue_byte(8'h0A, NoCheck);
    end
  endtask

  task automatic drain();
    while (tx_q.size() > 0 || push || verdict_q.size() > 0) @(negedge clk);
    repeat (Settle) @(negedge clk);
  endtask

  task automatic write_cfg(input logic drop, input logic own);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DROP_BAD;
    cfg_wdata <= drop;
    @(posedge clk);
    cfg_index <= CFG_OWN_VES;
    cfg_wdata <= own;
    @(posedge clk);
    cfg_we <= 1'b0;
    drop_bad = drop;
    own_ves = own;
    @(negedge clk);
  endtask

  row_t rows [$];
  logic drop_set [0:3];
  logic own_set [0:3];

  // one row of the directed table
  task automatic add_row(input string body, input bit add_cs, input int st);
    row_t r;
    r.body = body;
    r.add_cs = add_cs;
    r.st = st;
    rows = {rows, r};
  endtask

  initial begin
    int phase_bytes;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = 1'b0;
    drop_bad = 1'b1;
    own_ves = 1'b0;
    mismatches = 0;
    verdicts_seen = 0;
    bytes_queued = 0;
    quiet = 1'b0;
    hold_go = 1'b0;
    hold_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed sentences under reset settings
    add_row("$GPGGA,1,2", 1'b0, ST_IGNORED);
    add_row("!AIV", 1'b0, ST_IGNORED);
    add_row("!AIVDM,1,1*00", 1'b0, ST_SHORT);
    add_row("!aIVDM,1,1,,A,1,0", 1'b1, ST_TALKER);
    add_row("!AIVDM,0,1,,A,1,0", 1'b1, ST_HEADER);
    add_row("!AIVDM,1,1,,A,1,0*G1", 1'b0, ST_TAIL);
    add_row("!AIVDM,1,1,,A,1,6", 1'b1, ST_FILL);
    add_row("!AIVDM,1,1,12,A,1,0", 1'b1, ST_ID);
    add_row("!AIVDM,1,1,,AB,1,0", 1'b1, ST_CHANNEL);
    add_row("!AIVDM,1,1,,A,0", 1'b1, ST_EMPTY);
    add_row("!AIVDM,1,1,,A,1~3,0", 1'b1, ST_CHAR);
    add_row("!AIVDM,1,1,,A,12,3,0", 1'b1, ST_PARTS);
    add_row("!AIVDO,1,1,,A,1,0", 1'b1, ST_IGNORED);
    add_row("!AIVDM,1,1,,A,15M67FC000G?ufbE`FepT@3n00Sa,0", 1'b1, ST_OK);
    add_row("!AIVDM,2,1,3,,1P,2", 1'b1, ST_OK);
    add_row("!B9VDM,9,9,Z,B,w,5", 1'b1, ST_OK);
    add_row("!AIVDM,1,1,,A,1,0*00", 1'b0, NoCheck);
    add_row("!AIVDM,1,1,,B,0W,1*7f", 1'b0, NoCheck);
    add_row("{noise,1*00", 1'b0, NoCheck);
    add_row("\\x,2", 1'b0, NoCheck);
    add_row("\254zz", 1'b0, NoCheck);
    foreach (rows[i]) queue_text(rows[i].body, rows[i].add_cs, rows[i].st);
    drain();

    // random phases, each under its own settings
    drop_set = '{1'b1, 1'b0, 1'b1, 1'b0};
    own_set  = '{1'b0, 1'b1, 1'b1, 1'b0};
    for (int p = 0; p < 4; p++) begin
      write_cfg(drop_set[p], own_set[p]);
      phase_bytes = bytes_queued + 230;
      if (p == 0) hold_go = 1'b1;
      if (p == 3) quiet = 1'b1;
      while (bytes_queued < phase_bytes || (p == 3 && verdicts_seen < 60)) begin
        queue_sentence();
        while (tx_q.size() > 64) @(negedge clk);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
